>>> hdl/mfr_pkg.sv
package mfr_pkg;

  // Default build sizes
  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int MAX_HEIGHT_DEF  = 2048;
  localparam int WINDOW_SIZE_DEF = 3;

  // Pixel layout: channel 0 blue, 1 green, 2 red
  localparam int CHANNELS = 3;
  localparam int CHAN_W   = 8;

  // Configuration port
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Result queue depth, covers the words in flight at full rate
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [CHANNELS-1:0][CHAN_W-1:0] pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] red_in;
    logic              flush;
  } pix_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] red_out;
    logic              frame_end;
  } res_word_t;

endpackage

>>> hdl/median_filter_3x3_rgb.sv
// A result word is offered once the input word that completes it has been accepted and
//   has passed stages B and C; the first result of a frame needs pad rows plus pad pixels.
// Throughput: one word per cycle while the queue has room, set by the line buffer RAM
//   (one read, one write a cycle) and rank selector; 4-entry queue absorbs output stalls.
// Reset (synchronous, active high): positions, flags and queue clear, frame size
//   returns to 640x480; line buffer and window contents are not cleared.
module median_filter_3x3_rgb #(
  parameter int MAX_WIDTH   = mfr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = mfr_pkg::MAX_HEIGHT_DEF,
  parameter int WINDOW_SIZE = mfr_pkg::WINDOW_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // pixel words in
  input  logic                         pix_valid,
  output logic                         pix_ready,
  input  mfr_pkg::pix_word_t           pix,
  // filtered words out
  output logic                         res_valid,
  input  logic                         res_ready,
  output mfr_pkg::res_word_t           res,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfr_pkg::CFG_W-1:0]    cfg_data
);
  import mfr_pkg::*;

  localparam int PAD        = WINDOW_SIZE / 2;
  localparam int WIN_N      = WINDOW_SIZE * WINDOW_SIZE;
  localparam int STORE_ROWS = WINDOW_SIZE - 1;
  localparam int PIX_W      = CHANNELS * CHAN_W;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int LW         = $clog2(PAD * MAX_WIDTH + PAD + 1);
  localparam int RKW        = $clog2(WIN_N);
  localparam int FW         = $clog2(FIFO_DEPTH);
  localparam int CW         = FW + 1;
  localparam int W_RST      = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int H_RST      = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  // one line buffer address holds the column's pixels of all stored rows,
  // entry 0 the newest row
  typedef logic [STORE_ROWS-1:0][PIX_W-1:0] row_word_t;

  // clamp a size register: zero acts as one, oversize acts as the maximum
  function automatic int eff_size(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // middle of the sorted values: the element with rank n/2, ties broken by position
  function automatic logic [CHAN_W-1:0] median_of(input logic [WIN_N-1:0][CHAN_W-1:0] v);
    logic [CHAN_W-1:0] m;
    logic [RKW-1:0]    rank;
    m = '0;
    for (int i = 0; i < WIN_N; i++) begin
      rank = '0;
      for (int j = 0; j < WIN_N; j++) begin
        if (j != i) begin
          if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) begin
            rank = rank + RKW'(1);
          end
        end
      end
      if (rank == RKW'(WIN_N / 2)) begin
        m = v[i];
      end
    end
    return m;
  endfunction

  // ---------------------------------------------------------------
  // Frame size registers, kept as last index (size minus one)
  // ---------------------------------------------------------------
  logic [XW-1:0] w_last;
  logic [YW-1:0] h_last;
  logic          cfg_write;
  logic          cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    unique case (cfg_index)
      REG_FRAME_WIDTH:  cfg_hit = 1'b1;
      REG_FRAME_HEIGHT: cfg_hit = 1'b1;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= XW'(W_RST - 1);
      h_last <= YW'(H_RST - 1);
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        w_last <= XW'(eff_size(int'(cfg_data), MAX_WIDTH) - 1);
      end
      if (cfg_index == REG_FRAME_HEIGHT) begin
        h_last <= YW'(eff_size(int'(cfg_data), MAX_HEIGHT) - 1);
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage A: accept, stream positions, line buffer read
  // ---------------------------------------------------------------
  logic [XW-1:0] in_column, in_column_next;
  logic [YW-1:0] in_row, in_row_next;
  logic          draining, draining_next;     // whole frame in, only drain words now
  logic [XW-1:0] out_column, out_column_next;
  logic [YW-1:0] out_row, out_row_next;
  logic [LW-1:0] lead, lead_next;             // words taken, saturates at the lag
  logic [LW-1:0] lag;

  logic accept, take, due, col_wrap, out_wrap, interior, last;

  logic [CW-1:0] count;
  logic          b_valid, c_valid;

  assign pix_ready = (int'(count) + int'(b_valid) + int'(c_valid)) < FIFO_DEPTH;
  assign accept    = pix_valid && pix_ready;
  // a flush before the frame is all in is dropped without effect
  assign take      = accept && !(pix.flush && !draining);

  assign lag      = LW'(PAD * (int'(w_last) + 1) + PAD);
  assign due      = (lead == lag);
  assign col_wrap = (in_column == w_last);
  assign out_wrap = (out_column == w_last);
  assign last     = (out_row == h_last) && out_wrap;
  assign interior = (int'(out_row) >= PAD) && (int'(out_row) + PAD <= int'(h_last))
                 && (int'(out_column) >= PAD) && (int'(out_column) + PAD <= int'(w_last));

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    draining_next   = draining;
    out_column_next = out_column;
    out_row_next    = out_row;
    lead_next       = lead;
    if (take) begin
      in_column_next = col_wrap ? '0 : in_column + XW'(1);
      if (col_wrap && !draining) begin
        in_row_next = in_row + YW'(1);
        if (in_row == h_last) begin
          draining_next = 1'b1;
        end
      end
      if (!due) begin
        lead_next = lead + LW'(1);
      end else begin
        out_column_next = out_wrap ? '0 : out_column + XW'(1);
        if (out_wrap) begin
          out_row_next = out_row + YW'(1);
        end
        // last word of the frame: next word starts a new frame
        if (last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          draining_next   = 1'b0;
          out_column_next = '0;
          out_row_next    = '0;
          lead_next       = '0;
        end
      end
    end
    // a write to a frame size register restarts the frame
    if (cfg_write && cfg_hit) begin
      in_column_next  = '0;
      in_row_next     = '0;
      draining_next   = 1'b0;
      out_column_next = '0;
      out_row_next    = '0;
      lead_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      draining   <= 1'b0;
      out_column <= '0;
      out_row    <= '0;
      lead       <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      draining   <= draining_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      lead       <= lead_next;
    end
  end

  // line buffer: read at the word's column on accept, written back in the next cycle
  row_word_t mem [MAX_WIDTH];
  row_word_t rd_word;
  row_word_t wr_word;
  row_word_t old_word;
  logic [XW-1:0] b_x;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= mem[in_column];
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      mem[b_x] <= wr_word;
    end
  end

  // ---------------------------------------------------------------
  // Stage B: build new column, update line buffer and window
  // ---------------------------------------------------------------
  pixel_t    b_pix;
  logic      b_due, b_interior, b_last;
  logic      b_fwd;          // previous word wrote this column in the read cycle
  row_word_t b_fwd_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix      <= draining ? '0 : {pix.red_in, pix.green_in, pix.blue_in};
      b_x        <= in_column;
      b_due      <= due;
      b_interior <= interior;
      b_last     <= last;
      b_fwd      <= b_valid && (b_x == in_column);
      b_fwd_word <= wr_word;
    end
  end

  pixel_t col [WINDOW_SIZE];

  always_comb begin
    old_word = b_fwd ? b_fwd_word : rd_word;
    // oldest row at top, incoming pixel at bottom
    col[WINDOW_SIZE-1] = b_pix;
    for (int k = 0; k < STORE_ROWS; k++) begin
      col[WINDOW_SIZE-2-k] = old_word[k];
    end
    wr_word[0] = b_pix;
    for (int k = 1; k < STORE_ROWS; k++) begin
      wr_word[k] = old_word[k-1];
    end
  end

  pixel_t win [WINDOW_SIZE][WINDOW_SIZE];

  always_ff @(posedge clk) begin
    if (b_valid) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        for (int j = 0; j < WINDOW_SIZE - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
        win[i][WINDOW_SIZE-1] <= col[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage C: per-channel median or pass-through into result queue
  // ---------------------------------------------------------------
  logic c_interior, c_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid && b_due;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      c_interior <= b_interior;
      c_last     <= b_last;
    end
  end

  logic [CHANNELS-1:0][WIN_N-1:0][CHAN_W-1:0] vals;
  pixel_t    filt;
  res_word_t med_word;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        for (int j = 0; j < WINDOW_SIZE; j++) begin
          vals[ch][i*WINDOW_SIZE+j] = win[i][j][ch];
        end
      end
      filt[ch] = c_interior ? median_of(vals[ch]) : win[PAD][PAD][ch];
    end
    med_word.blue_out  = filt[0];
    med_word.green_out = filt[1];
    med_word.red_out   = filt[2];
    med_word.frame_end = c_last;
  end

  // result queue
  res_word_t   fifo [FIFO_DEPTH];
  logic [FW-1:0] wr_ptr, rd_ptr;
  logic          push, pop;

  assign push      = c_valid;
  assign res_valid = (count != '0);
  assign pop       = res_valid && res_ready;
  assign res       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= med_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FW'(1);
      if (pop)  rd_ptr <= rd_ptr + FW'(1);
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule
